FILE: hw/rtl/lmts_pkg.sv
// Shared widths, command and register codes, and the job types of the text scroller.
package lmts_pkg;

    localparam int MAX_TEXT_DEF = 64;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int GLYPH_AW   = CHAR_W + ROW_W;
    localparam int DIR_W      = 3;
    localparam int LEN_W      = 7;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_TEXT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_GLYPH = 2'd3;

    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_ROTATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_LENGTH  = 2'd2;

    localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

    typedef enum logic [1:0] {
        MODE_UP,
        MODE_DOWN,
        MODE_LEFT,
        MODE_RIGHT
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [SHIFT_W-1:0] shift;
        logic               finished;
    } job_t;

    typedef struct packed {
        logic load;
        job_t job;
    } job_req_t;

    typedef struct packed {
        logic free;
        logic job_active;
    } pipe_stat_t;

endpackage

FILE: hw/rtl/lmts_in_if.sv
// Request channel that carries commands and load data into the scroller.
interface lmts_in_if import lmts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  glyph_row;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, cmd, position, char_code, glyph_row, data_byte,
                    input ready);
    modport sink (input valid, cmd, position, char_code, glyph_row, data_byte,
                  output ready);
endinterface

FILE: hw/rtl/lmts_out_if.sv
// Result channel that carries the frame rows out of the scroller.
interface lmts_out_if import lmts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_index;
    logic [BYTE_W-1:0] row_bits;
    logic              last;
    logic              finished;

    modport source (output valid, row_index, row_bits, last, finished, input ready);
    modport sink (input valid, row_index, row_bits, last, finished, output ready);
endinterface

FILE: hw/rtl/lmts_cfg_if.sv
// Register write channel of the scroller.
interface lmts_cfg_if import lmts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/led_matrix_text_scroller.sv
// Top level of the 8x8 LED matrix text scroller.
//
// Channel  Dir  Payload                                      Accepted when
// item     in   cmd, position, char_code, glyph_row, data     item.valid && item.ready
// row      out  row_index, row_bits, last, finished          row.valid && row.ready
// cfg      in   index, data                                  cfg.valid && cfg.ready
//
// A tick with an active direction occupies the row sequencer for a frame, one row per cycle
// unless the row channel stalls, bounded by the two read ports of the glyph memory; a new
// request is taken in the cycle the last row of the frame is read. The first row of a frame
// passes the text read, the glyph read and the output register. Reset clears direction,
// rotate flag and scroll position and sets the length to 1; both stores are undefined until
// loaded. A stall on the row channel holds the pipeline and, once it backs up, the item channel.
module led_matrix_text_scroller import lmts_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    lmts_in_if.sink    item,
    lmts_out_if.source row,
    lmts_cfg_if.sink   cfg
);

    localparam int TW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

    pipe_stat_t          stat;
    job_req_t            job_req;
    logic                text_we;
    logic [TW-1:0]       text_waddr;
    logic [CHAR_W-1:0]   text_wdata;
    logic                text_re;
    logic [TW-1:0]       text_raddr_a;
    logic [TW-1:0]       text_raddr_b;
    logic [CHAR_W-1:0]   c1;
    logic [CHAR_W-1:0]   c2;
    logic                glyph_we;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic [BYTE_W-1:0]   glyph_wdata;
    logic                glyph_re;
    logic [GLYPH_AW-1:0] glyph_raddr_a;
    logic [GLYPH_AW-1:0] glyph_raddr_b;
    logic [BYTE_W-1:0]   glyph_rdata_a;
    logic [BYTE_W-1:0]   glyph_rdata_b;

    lmts_scroll_ctrl #(
        .MAX_TEXT (MAX_TEXT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg),
        .stat         (stat),
        .job_req      (job_req),
        .text_we      (text_we),
        .text_waddr   (text_waddr),
        .text_wdata   (text_wdata),
        .text_re      (text_re),
        .text_raddr_a (text_raddr_a),
        .text_raddr_b (text_raddr_b),
        .glyph_we     (glyph_we),
        .glyph_waddr  (glyph_waddr),
        .glyph_wdata  (glyph_wdata)
    );

    lmts_text_store #(
        .MAX_TEXT (MAX_TEXT)
    ) u_text (
        .clk     (clk),
        .we      (text_we),
        .waddr   (text_waddr),
        .wdata   (text_wdata),
        .re      (text_re),
        .raddr_a (text_raddr_a),
        .raddr_b (text_raddr_b),
        .rdata_a (c1),
        .rdata_b (c2)
    );

    lmts_glyph_store u_glyph (
        .clk     (clk),
        .we      (glyph_we),
        .waddr   (glyph_waddr),
        .wdata   (glyph_wdata),
        .re      (glyph_re),
        .raddr_a (glyph_raddr_a),
        .raddr_b (glyph_raddr_b),
        .rdata_a (glyph_rdata_a),
        .rdata_b (glyph_rdata_b)
    );

    lmts_row_pipe u_rows (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_req       (job_req),
        .stat          (stat),
        .c1            (c1),
        .c2            (c2),
        .glyph_re      (glyph_re),
        .glyph_raddr_a (glyph_raddr_a),
        .glyph_raddr_b (glyph_raddr_b),
        .glyph_rdata_a (glyph_rdata_a),
        .glyph_rdata_b (glyph_rdata_b),
        .row           (row)
    );

    a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
        job_req.load |=> stat.job_active)
        else $error("Accepted tick did not start a frame.");

    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        row.valid && !row.last |=> row.valid)
        else $error("Frame rows are not delivered back to back.");

    a_frame_flag: assert property (@(posedge clk) disable iff (!rst_n)
        row.valid && row.ready && !row.last |=> row.finished == $past(row.finished))
        else $error("Finished flag changed within a frame.");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        row.valid |-> (row.last == (row.row_index == LAST_ROW)))
        else $error("Last marker does not match the row index.");

endmodule

FILE: hw/rtl/lmts_text_store.sv
// Text memory: one write port and two registered read ports.
module lmts_text_store import lmts_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    localparam int TW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [TW-1:0]     waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic              re,
    input  logic [TW-1:0]     raddr_a,
    input  logic [TW-1:0]     raddr_b,
    output logic [CHAR_W-1:0] rdata_a,
    output logic [CHAR_W-1:0] rdata_b
);

    logic [CHAR_W-1:0] mem [MAX_TEXT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hw/rtl/lmts_glyph_store.sv
// Glyph memory of 256 glyphs by 8 rows: one write port and two registered read ports.
module lmts_glyph_store import lmts_pkg::*; (
    input  logic                clk,
    input  logic                we,
    input  logic [GLYPH_AW-1:0] waddr,
    input  logic [BYTE_W-1:0]   wdata,
    input  logic                re,
    input  logic [GLYPH_AW-1:0] raddr_a,
    input  logic [GLYPH_AW-1:0] raddr_b,
    output logic [BYTE_W-1:0]   rdata_a,
    output logic [BYTE_W-1:0]   rdata_b
);

    logic [BYTE_W-1:0] mem [2**GLYPH_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hw/rtl/lmts_scroll_ctrl.sv
// Command decode, configuration registers and scroll position stepping.
module lmts_scroll_ctrl import lmts_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    localparam int TW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1,
    localparam int CW = $clog2(8 * MAX_TEXT) + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    lmts_in_if.sink             item,
    lmts_cfg_if.sink            cfg,
    input  pipe_stat_t          stat,
    output job_req_t            job_req,
    output logic                text_we,
    output logic [TW-1:0]       text_waddr,
    output logic [CHAR_W-1:0]   text_wdata,
    output logic                text_re,
    output logic [TW-1:0]       text_raddr_a,
    output logic [TW-1:0]       text_raddr_b,
    output logic                glyph_we,
    output logic [GLYPH_AW-1:0] glyph_waddr,
    output logic [BYTE_W-1:0]   glyph_wdata
);

    localparam int CCW = CW - 3;
    localparam int XW  = (CW > LEN_W) ? CW : LEN_W;

    logic [DIR_W-1:0] dir_reg;
    logic             cyc_reg;
    logic [LEN_W-1:0] len_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             fin_reg;
    logic             fin_next;

    logic [XW-1:0]      len_x;
    logic [CW-1:0]      len_eff;
    logic [CW-1:0]      len8;
    logic [CW-1:0]      start_fall;
    logic [CW-1:0]      end_rise;
    logic [CW-1:0]      cnt_inc;
    logic [CCW-1:0]     cc;
    logic [CCW-1:0]     cc_inc;
    logic [CCW-1:0]     cn;
    logic [CCW-1:0]     len_cc;
    logic               rising;
    logic               falling;
    logic               wrap;
    logic               accept;
    logic               tick_go;
    logic [SHIFT_W-1:0] shift;
    mode_t              mode;

    assign cfg.ready  = 1'b1;
    assign item.ready = stat.free;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        len_x = XW'(len_reg);
        if (len_x == '0)
        begin
            len_x = XW'(1);
        end
        else if (len_x > XW'(MAX_TEXT))
        begin
            len_x = XW'(MAX_TEXT);
        end
        len_eff    = CW'(len_x);
        len8       = {len_eff[CW-4:0], 3'b000};
        start_fall = len8 - CW'(1);
        end_rise   = cyc_reg ? len8 : (len8 - CW'(8));
        len_cc     = len_eff[CCW-1:0];

        rising  = (dir_reg == DIR_UP) || (dir_reg == DIR_LEFT);
        falling = (dir_reg == DIR_DOWN) || (dir_reg == DIR_RIGHT);

        cc     = count_reg[CW-1:3];
        cc_inc = cc + CCW'(1);
        if (rising)
        begin
            cn = (cc_inc >= len_cc) ? '0 : cc_inc;
        end
        else
        begin
            cn = (cc == '0) ? (len_cc - CCW'(1)) : (cc - CCW'(1));
        end

        if (rising)
        begin
            shift = {1'b0, count_reg[2:0]};
        end
        else
        begin
            shift = SHIFT_W'(8) - {1'b0, count_reg[2:0]};
        end

        unique case (dir_reg)
            DIR_UP:   mode = MODE_UP;
            DIR_DOWN: mode = MODE_DOWN;
            DIR_LEFT: mode = MODE_LEFT;
            default:  mode = MODE_RIGHT;
        endcase

        cnt_inc = count_reg + CW'(1);
        if (rising)
        begin
            wrap = (cnt_inc >= end_rise);
        end
        else
        begin
            wrap = cyc_reg ? (count_reg == '0) : (count_reg <= CW'(8));
        end

        tick_go    = 1'b0;
        text_we    = 1'b0;
        glyph_we   = 1'b0;
        count_next = count_reg;
        fin_next   = fin_reg;

        if (accept)
        begin
            unique case (item.cmd)
                CMD_TICK:
                begin
                    if (rising || falling)
                    begin
                        tick_go = 1'b1;
                        if (wrap)
                        begin
                            count_next = rising ? '0 : start_fall;
                            fin_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = rising ? cnt_inc : (count_reg - CW'(1));
                        end
                    end
                end
                CMD_RESTART:
                begin
                    count_next = falling ? start_fall : '0;
                    fin_next   = 1'b0;
                end
                CMD_LOAD_TEXT:
                begin
                    text_we = (32'(item.position) < 32'(MAX_TEXT));
                end
                CMD_LOAD_GLYPH:
                begin
                    glyph_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign text_waddr   = TW'(item.position);
    assign text_wdata   = item.char_code;
    assign text_re      = tick_go;
    assign text_raddr_a = cc[TW-1:0];
    assign text_raddr_b = cn[TW-1:0];
    assign glyph_waddr  = {item.char_code, item.glyph_row};
    assign glyph_wdata  = item.data_byte;

    assign job_req.load         = tick_go;
    assign job_req.job.mode     = mode;
    assign job_req.job.shift    = shift;
    assign job_req.job.finished = fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            cyc_reg   <= 1'b0;
            len_reg   <= LEN_W'(1);
            count_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fin_reg   <= fin_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_DIRECTION:    dir_reg <= cfg.data[DIR_W-1:0];
                    REG_CYCLE_ROTATE: cyc_reg <= cfg.data[0];
                    REG_TEXT_LENGTH:  len_reg <= cfg.data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: hw/rtl/lmts_row_pipe.sv
// Row sequencer: glyph reads, shift and merge of two glyphs, output register.
module lmts_row_pipe import lmts_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  job_req_t            job_req,
    output pipe_stat_t          stat,
    input  logic [CHAR_W-1:0]   c1,
    input  logic [CHAR_W-1:0]   c2,
    output logic                glyph_re,
    output logic [GLYPH_AW-1:0] glyph_raddr_a,
    output logic [GLYPH_AW-1:0] glyph_raddr_b,
    input  logic [BYTE_W-1:0]   glyph_rdata_a,
    input  logic [BYTE_W-1:0]   glyph_rdata_b,
    lmts_out_if.source          row
);

    logic               job_vld_reg;
    logic               job_vld_next;
    job_t               job_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic               g_vld_reg;
    logic               g_vld_next;
    mode_t              g_mode_reg;
    logic [SHIFT_W-1:0] g_shift_reg;
    logic [ROW_W-1:0]   g_row_reg;
    logic               g_fin_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [BYTE_W-1:0]  out_bits_reg;
    logic               out_fin_reg;

    logic                out_load;
    logic                g_free;
    logic                issue;
    logic                last_issue;
    logic [SHIFT_W-1:0]  r_ext;
    logic [SHIFT_W-1:0]  up_row;
    logic [SHIFT_W-1:0]  down_row;
    logic [CHAR_W-1:0]   a_code;
    logic [ROW_W-1:0]    a_row;
    logic [2*BYTE_W-1:0] left_word;
    logic [2*BYTE_W-1:0] right_word;
    logic [BYTE_W-1:0]   bits;

    always_comb
    begin
        out_load   = g_vld_reg && (!out_vld_reg || row.ready);
        g_free     = !g_vld_reg || out_load;
        issue      = job_vld_reg && g_free;
        last_issue = issue && (row_reg == LAST_ROW);

        stat.free       = !job_vld_reg || last_issue;
        stat.job_active = job_vld_reg;

        job_vld_next = job_vld_reg;
        if (job_req.load)
        begin
            job_vld_next = 1'b1;
        end
        else if (last_issue)
        begin
            job_vld_next = 1'b0;
        end

        row_next = row_reg;
        if (job_req.load)
        begin
            row_next = '0;
        end
        else if (issue)
        begin
            row_next = row_reg + ROW_W'(1);
        end

        g_vld_next = g_vld_reg;
        if (issue)
        begin
            g_vld_next = 1'b1;
        end
        else if (out_load)
        begin
            g_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (row.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Vertical modes pick one glyph row; horizontal modes read the same row of both glyphs.
    always_comb
    begin
        r_ext    = {1'b0, row_reg};
        up_row   = r_ext + job_reg.shift;
        down_row = r_ext - job_reg.shift;
        case (job_reg.mode)
            MODE_UP:
            begin
                a_code = up_row[ROW_W] ? c2 : c1;
                a_row  = up_row[ROW_W-1:0];
            end
            MODE_DOWN:
            begin
                a_code = (r_ext >= job_reg.shift) ? c1 : c2;
                a_row  = down_row[ROW_W-1:0];
            end
            default:
            begin
                a_code = c1;
                a_row  = row_reg;
            end
        endcase
    end

    assign glyph_re      = issue;
    assign glyph_raddr_a = {a_code, a_row};
    assign glyph_raddr_b = {c2, row_reg};

    always_comb
    begin
        left_word  = {glyph_rdata_b, glyph_rdata_a} >> g_shift_reg;
        right_word = {glyph_rdata_a, glyph_rdata_b} << g_shift_reg;
        case (g_mode_reg)
            MODE_LEFT:  bits = left_word[BYTE_W-1:0];
            MODE_RIGHT: bits = right_word[2*BYTE_W-1:BYTE_W];
            default:    bits = glyph_rdata_a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_vld_reg <= 1'b0;
            row_reg     <= '0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            job_vld_reg <= job_vld_next;
            row_reg     <= row_next;
            g_vld_reg   <= g_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_req.load)
        begin
            job_reg <= job_req.job;
        end
        if (issue)
        begin
            g_mode_reg  <= job_reg.mode;
            g_shift_reg <= job_reg.shift;
            g_row_reg   <= row_reg;
            g_fin_reg   <= job_reg.finished;
        end
        if (out_load)
        begin
            out_row_reg  <= g_row_reg;
            out_bits_reg <= bits;
            out_fin_reg  <= g_fin_reg;
        end
    end

    assign row.valid     = out_vld_reg;
    assign row.row_index = out_row_reg;
    assign row.row_bits  = out_bits_reg;
    assign row.last      = (out_row_reg == LAST_ROW);
    assign row.finished  = out_fin_reg;

endmodule
